/* hw/rtl/tdr_pkg.sv */
// Shared types and constants of the triangle depth rasterizer.
package tdr_pkg;

  localparam int CW = 12;
  localparam int DW = 14;
  localparam int BW = 12;
  localparam int AW = 28;
  localparam int EW = 32;
  localparam int PW = 13;
  localparam int OW = 16;

  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] DIV_NUM0  = 2'd0;
  localparam logic [1:0] DIV_STEPX = 2'd1;
  localparam logic [1:0] DIV_STEPY = 2'd2;

  typedef struct packed {
    logic       load;
    logic [4:0] setup;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_cap;
    logic       walk_init;
    logic       walk_step;
    logic       clr_init;
    logic       clr_en;
    logic       rd_issue;
    logic       rd_cap;
    logic       rej_set;
  } tdr_cmd_t;

  typedef struct packed {
    logic reject;
    logic empty;
    logic div_done;
    logic walk_last;
    logic clr_last;
  } tdr_sts_t;

endpackage

/* hw/rtl/triangle_depth_rasterizer.sv */
// Top level: triangle depth rasterizer with a tile depth store.
// Draw: accept, the setup steps, 3 divisions (depth, x step, y step), a walk over each
//   bounding-box pixel, a drain step and done; a rejected or empty draw ends in setup.
// Read and clear also end in done; one item at a time, set by busy_o.
// Reset sweeps the whole store to the far value, busy high.
// done_o marks the one cycle a result is valid; the receiver cannot stall it.
module triangle_depth_rasterizer import tdr_pkg::*; #(
  parameter int TILE_WIDTH  = 64,
  parameter int TILE_HEIGHT = 64,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic [1:0]           mode_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic [15:0]          az_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic [15:0]          bz_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic [15:0]          cz_i,
  input  logic [5:0]           pixel_x_i,
  input  logic [5:0]           pixel_y_i,
  output logic                 done_o,
  output logic [PW-1:0]        pixels_written_o,
  output logic                 rejected_o,
  output logic [OW-1:0]        depth_value_o
);

  tdr_cmd_t cmd;
  tdr_sts_t sts;

  tdr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  tdr_dp #(
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .ax_i             (ax_i),
    .ay_i             (ay_i),
    .az_i             (az_i),
    .bx_i             (bx_i),
    .by_i             (by_i),
    .bz_i             (bz_i),
    .cx_i             (cx_i),
    .cy_i             (cy_i),
    .cz_i             (cz_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .pixels_written_o (pixels_written_o),
    .rejected_o       (rejected_o),
    .depth_value_o    (depth_value_o)
  );

endmodule

/* hw/rtl/tdr_ram.sv */
// Generic simple dual-port RAM with registered read.
module tdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tdr_div.sv */
// Iterative signed floor divider by a positive divisor, one quotient bit per cycle.
module tdr_div #(
  parameter int NW  = 51,
  parameter int DVW = 27
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [NW-1:0]  num_i,
  input  logic [DVW-1:0]        den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic signed [NW-1:0]  quo_o,
  output logic [DVW-1:0]        rem_o
);

  localparam int CNW = $clog2(NW + 1);

  logic [CNW-1:0] cnt_q;
  logic           busy_q, done_q, neg_q;
  logic [NW-1:0]  a_q;
  logic [DVW-1:0] rem_q;
  logic [DVW:0]   trial;
  logic           ge;
  logic [DVW:0]   rem_n;
  logic           rem_zero;

  assign trial    = {rem_q, a_q[NW-1]};
  assign ge       = trial >= {1'b0, den_i};
  assign rem_n    = ge ? trial - {1'b0, den_i} : trial;
  assign rem_zero = rem_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      a_q   <= num_i[NW-1] ? -num_i : num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[NW-2:0], ge};
      rem_q <= rem_n[DVW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = !neg_q ? signed'(a_q) : (rem_zero ? -signed'(a_q) : -signed'(a_q + NW'(1)));
  assign rem_o  = (neg_q && !rem_zero) ? den_i - rem_q : rem_q;

endmodule

/* hw/rtl/tdr_dp.sv */
// Datapath: vertex setup, edge and depth stepping, depth store and results.
module tdr_dp import tdr_pkg::*; #(
  parameter int TILE_WIDTH  = 64,
  parameter int TILE_HEIGHT = 64,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdr_cmd_t             cmd_i,
  output tdr_sts_t             sts_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic [15:0]          az_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic [15:0]          bz_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic [15:0]          cz_i,
  input  logic [5:0]           pixel_x_i,
  input  logic [5:0]           pixel_y_i,
  output logic [PW-1:0]        pixels_written_o,
  output logic                 rejected_o,
  output logic [OW-1:0]        depth_value_o
);

  localparam int DB   = DEPTH_BITS;
  localparam int NW   = DB + EW + 3;
  localparam int DVW  = AW - 1;
  localparam int NPIX = TILE_WIDTH * TILE_HEIGHT;
  localparam int MA   = $clog2(NPIX);
  localparam int PEW  = DW + BW + 5;
  localparam int ZDW  = DB + 1 + DW;
  localparam int ZEW  = DB + 1 + EW;
  localparam logic signed [BW-1:0] XMAX  = BW'(TILE_WIDTH - 1);
  localparam logic signed [BW-1:0] YMAX  = BW'(TILE_HEIGHT - 1);
  localparam logic signed [BW-1:0] BZERO = '0;
  localparam logic [DB-1:0]        FAR   = {DB{1'b1}};

  logic                  cull_q;
  logic signed [CW-1:0]  px_q [3];
  logic signed [CW-1:0]  py_q [3];
  logic [DB-1:0]         pz_q [3];
  logic [5:0]            pix_x_q, pix_y_q;
  logic signed [DW-1:0]  dx_q [3];
  logic signed [DW-1:0]  dy_q [3];
  logic signed [BW-1:0]  left_q, right_q, down_q, top_q;
  logic signed [2*DW-1:0] ma_q, mb_q;
  logic signed [PEW-1:0] pea_q [3];
  logic signed [PEW-1:0] peb_q [3];
  logic signed [ZDW-1:0] zdx_q [3];
  logic signed [ZDW-1:0] zdy_q [3];
  logic signed [AW-1:0]  area_q;
  logic signed [EW-1:0]  e0_q [3];
  logic signed [ZEW-1:0] ze_q [3];
  logic signed [NW-1:0]  sx_q, sy_q, num0_q;
  logic signed [NW-1:0]  q0_q, sxq_q, syq_q;
  logic [DVW-1:0]        r0_q, sxr_q, syr_q;
  logic signed [BW-1:0]  x_q, y_q;
  logic signed [EW-1:0]  e_q [3];
  logic signed [EW-1:0]  erow_q [3];
  logic signed [NW-1:0]  zq_q, rowq_q;
  logic [DVW-1:0]        zr_q, rowr_q;
  logic                  vld_b_q;
  logic [MA-1:0]         wa_b_q;
  logic [DB-1:0]         z_b_q;
  logic [MA-1:0]         clr_cnt_q;
  logic [PW-1:0]         pw_q;
  logic                  rej_q;
  logic [OW-1:0]         dv_q;

  // Bounding box
  logic signed [CW-1:0] minx, maxx, miny, maxy;
  logic signed [CW:0]   miny_up;
  logic signed [BW-1:0] fl_minx, fl_maxx, fl_maxy, cl_miny;

  always_comb begin
    minx = px_q[0];
    maxx = px_q[0];
    miny = py_q[0];
    maxy = py_q[0];
    for (int i = 1; i < 3; i++) begin
      if (px_q[i] < minx) minx = px_q[i];
      if (px_q[i] > maxx) maxx = px_q[i];
      if (py_q[i] < miny) miny = py_q[i];
      if (py_q[i] > maxy) maxy = py_q[i];
    end
    miny_up = (CW + 1)'(miny) + (CW + 1)'(15);
    fl_minx = BW'(minx) >>> 4;
    fl_maxx = BW'(maxx) >>> 4;
    fl_maxy = BW'(maxy) >>> 4;
    cl_miny = BW'(miny_up >>> 4);
  end

  // Divider
  logic signed [NW-1:0] div_num, div_quo;
  logic [DVW-1:0]       div_den, div_rem;
  logic                 div_busy, div_done;

  assign div_den = area_q[DVW-1:0];

  always_comb begin
    case (cmd_i.div_sel)
      DIV_NUM0:  div_num = num0_q;
      DIV_STEPX: div_num = sx_q;
      default:   div_num = sy_q;
    endcase
  end

  tdr_div #(.NW(NW), .DVW(DVW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_q <= 1'b1;
    end else if (cfg_we_i) begin
      cull_q <= cfg_wdata_i;
    end
  end

  // Load and setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q[0] <= ax_i;
      py_q[0] <= ay_i;
      pz_q[0] <= DB'(az_i);
      pix_x_q <= pixel_x_i;
      pix_y_q <= pixel_y_i;
      if (cull_q) begin
        px_q[1] <= bx_i; py_q[1] <= by_i; pz_q[1] <= DB'(bz_i);
        px_q[2] <= cx_i; py_q[2] <= cy_i; pz_q[2] <= DB'(cz_i);
      end else begin
        px_q[1] <= cx_i; py_q[1] <= cy_i; pz_q[1] <= DB'(cz_i);
        px_q[2] <= bx_i; py_q[2] <= by_i; pz_q[2] <= DB'(bz_i);
      end
    end
    if (cmd_i.setup[0]) begin
      left_q  <= (fl_minx < BZERO) ? BZERO : fl_minx;
      right_q <= (fl_maxx > XMAX) ? XMAX : fl_maxx;
      down_q  <= (cl_miny < BZERO) ? BZERO : cl_miny;
      top_q   <= (fl_maxy > YMAX) ? YMAX : fl_maxy;
    end
    if (cmd_i.setup[1]) begin
      ma_q <= dy_q[0] * dx_q[2];
      mb_q <= dx_q[0] * dy_q[2];
    end
    if (cmd_i.setup[2]) begin
      area_q <= AW'(ma_q) - AW'(mb_q);
      sx_q   <= -((NW'(zdy_q[0]) + NW'(zdy_q[1]) + NW'(zdy_q[2])) <<< 4);
      sy_q   <= (NW'(zdx_q[0]) + NW'(zdx_q[1]) + NW'(zdx_q[2])) <<< 4;
    end
    if (cmd_i.setup[4]) begin
      num0_q <= NW'(ze_q[0]) + NW'(ze_q[1]) + NW'(ze_q[2]) + NW'(area_q >>> 1);
    end
    if (cmd_i.div_cap) begin
      case (cmd_i.div_sel)
        DIV_NUM0: begin
          q0_q <= div_quo;
          r0_q <= div_rem;
        end
        DIV_STEPX: begin
          sxq_q <= div_quo;
          sxr_q <= div_rem;
        end
        default: begin
          syq_q <= div_quo;
          syr_q <= div_rem;
        end
      endcase
    end
  end

  // Walk stepping
  logic [DVW:0]         rs_x, rs_y;
  logic                 cy_x, cy_y;
  logic [DVW-1:0]       zr_nx, rowr_n;
  logic signed [NW-1:0] zq_nx, rowq_n;
  logic                 last_x, covered;
  logic [MA-1:0]        walk_addr, pix_addr;

  assign rs_x   = {1'b0, zr_q} + {1'b0, sxr_q};
  assign cy_x   = rs_x >= {1'b0, div_den};
  assign zr_nx  = cy_x ? DVW'(rs_x - {1'b0, div_den}) : DVW'(rs_x);
  assign zq_nx  = zq_q + sxq_q + NW'(cy_x);
  assign rs_y   = {1'b0, rowr_q} + {1'b0, syr_q};
  assign cy_y   = rs_y >= {1'b0, div_den};
  assign rowr_n = cy_y ? DVW'(rs_y - {1'b0, div_den}) : DVW'(rs_y);
  assign rowq_n = rowq_q + syq_q + NW'(cy_y);
  assign last_x = x_q == right_q;
  assign covered = !e_q[0][EW-1] && !e_q[1][EW-1] && !e_q[2][EW-1];
  assign walk_addr = MA'(y_q) * MA'(TILE_WIDTH) + MA'(x_q);
  assign pix_addr  = MA'(pix_y_q) * MA'(TILE_WIDTH) + MA'(pix_x_q);

  for (genvar g = 0; g < 3; g++) begin : g_edge
    localparam int J = (g + 1) % 3;
    localparam int W = (g + 2) % 3;
    logic signed [BW+4:0] yo, xo;
    assign yo = ((BW + 5)'(down_q) <<< 4) - (BW + 5)'(py_q[g]);
    assign xo = ((BW + 5)'(left_q) <<< 4) - (BW + 5)'(px_q[g]);

    always_ff @(posedge clk_i) begin
      if (cmd_i.setup[0]) begin
        dx_q[g] <= DW'(px_q[J]) - DW'(px_q[g]);
        dy_q[g] <= DW'(py_q[J]) - DW'(py_q[g]);
      end
      if (cmd_i.setup[1]) begin
        pea_q[g] <= dx_q[g] * yo;
        peb_q[g] <= dy_q[g] * xo;
        zdx_q[g] <= $signed({1'b0, pz_q[W]}) * dx_q[g];
        zdy_q[g] <= $signed({1'b0, pz_q[W]}) * dy_q[g];
      end
      if (cmd_i.setup[2]) begin
        e0_q[g] <= EW'(pea_q[g]) - EW'(peb_q[g]);
      end
      if (cmd_i.setup[3]) begin
        ze_q[g] <= $signed({1'b0, pz_q[W]}) * e0_q[g];
      end
      if (cmd_i.walk_init) begin
        e_q[g]    <= e0_q[g];
        erow_q[g] <= e0_q[g];
      end else if (cmd_i.walk_step) begin
        if (last_x) begin
          erow_q[g] <= erow_q[g] + (EW'(dx_q[g]) <<< 4);
          e_q[g]    <= erow_q[g] + (EW'(dx_q[g]) <<< 4);
        end else begin
          e_q[g] <= e_q[g] - (EW'(dy_q[g]) <<< 4);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      x_q    <= left_q;
      y_q    <= down_q;
      zq_q   <= q0_q;
      zr_q   <= r0_q;
      rowq_q <= q0_q;
      rowr_q <= r0_q;
    end else if (cmd_i.walk_step) begin
      if (last_x) begin
        x_q    <= left_q;
        y_q    <= y_q + BW'(1);
        rowq_q <= rowq_n;
        rowr_q <= rowr_n;
        zq_q   <= rowq_n;
        zr_q   <= rowr_n;
      end else begin
        x_q  <= x_q + BW'(1);
        zq_q <= zq_nx;
        zr_q <= zr_nx;
      end
    end
    wa_b_q <= walk_addr;
    z_b_q  <= zq_q[DB-1:0];
  end

  // Depth store
  logic          ram_we, b_write;
  logic [MA-1:0] ram_wa, ram_ra;
  logic [DB-1:0] ram_wd, ram_rd;
  logic          in_tile;

  assign b_write = vld_b_q && (z_b_q < ram_rd);
  assign ram_we  = cmd_i.clr_en || b_write;
  assign ram_wa  = cmd_i.clr_en ? clr_cnt_q : wa_b_q;
  assign ram_wd  = cmd_i.clr_en ? FAR : z_b_q;
  assign ram_ra  = cmd_i.rd_issue ? pix_addr : walk_addr;
  assign in_tile = (int'(pix_x_q) < TILE_WIDTH) && (int'(pix_y_q) < TILE_HEIGHT);

  tdr_ram #(.WIDTH(DB), .DEPTH(NPIX)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q   <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      vld_b_q <= cmd_i.walk_step && covered;
      if (cmd_i.clr_init) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + MA'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pw_q  <= '0;
      rej_q <= 1'b0;
      dv_q  <= '0;
    end else begin
      if (b_write) pw_q <= pw_q + PW'(1);
      if (cmd_i.rej_set) rej_q <= 1'b1;
      if (cmd_i.rd_cap) dv_q <= in_tile ? OW'(ram_rd) : '0;
    end
  end

  assign sts_o.reject    = area_q[AW-1] || (area_q == '0);
  assign sts_o.empty     = (right_q < left_q) || (top_q < down_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.walk_last = last_x && (y_q == top_q);
  assign sts_o.clr_last  = clr_cnt_q == MA'(NPIX - 1);

  assign pixels_written_o = pw_q;
  assign rejected_o       = rej_q;
  assign depth_value_o    = dv_q;

  a_no_clear_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vld_b_q && cmd_i.clr_en)) else $error("depth write during clear sweep");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy) else $error("divider restarted while busy");
  a_walk_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> (x_q >= BZERO && x_q <= XMAX && y_q >= BZERO && y_q <= YMAX))
    else $error("walk left the tile");

endmodule

/* hw/rtl/tdr_ctrl.sv */
// Controller state machine sequencing setup, division, walk, read and clear.
module tdr_ctrl import tdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] mode_i,
  input  tdr_sts_t   sts_i,
  output tdr_cmd_t   cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_S1    = 4'd2;
  localparam logic [3:0] ST_S2    = 4'd3;
  localparam logic [3:0] ST_S3    = 4'd4;
  localparam logic [3:0] ST_S4    = 4'd5;
  localparam logic [3:0] ST_S5    = 4'd6;
  localparam logic [3:0] ST_DST   = 4'd7;
  localparam logic [3:0] ST_DWT   = 4'd8;
  localparam logic [3:0] ST_WINIT = 4'd9;
  localparam logic [3:0] ST_WALK  = 4'd10;
  localparam logic [3:0] ST_DRAIN = 4'd11;
  localparam logic [3:0] ST_RD1   = 4'd12;
  localparam logic [3:0] ST_RD2   = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       clr_cmd_q, clr_cmd_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    sel_d     = sel_q;
    clr_cmd_d = clr_cmd_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          clr_cmd_d  = mode_i == MODE_CLEAR;
          case (mode_i)
            MODE_DRAW: state_d = ST_S1;
            MODE_READ: state_d = ST_RD1;
            MODE_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = ST_CLR;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
      end
      ST_S1: begin
        cmd_o.setup[0] = 1'b1;
        state_d        = ST_S2;
      end
      ST_S2: begin
        cmd_o.setup[1] = 1'b1;
        state_d        = ST_S3;
      end
      ST_S3: begin
        cmd_o.setup[2] = 1'b1;
        state_d        = ST_S4;
      end
      ST_S4: begin
        cmd_o.setup[3] = 1'b1;
        if (sts_i.reject) begin
          cmd_o.rej_set = 1'b1;
          state_d       = ST_DONE;
        end else if (sts_i.empty) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_S5;
        end
      end
      ST_S5: begin
        cmd_o.setup[4] = 1'b1;
        sel_d          = DIV_NUM0;
        state_d        = ST_DST;
      end
      ST_DST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sel_q;
        state_d         = ST_DWT;
      end
      ST_DWT: begin
        cmd_o.div_sel = sel_q;
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          if (sel_q == DIV_STEPY) begin
            state_d = ST_WINIT;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_DST;
          end
        end
      end
      ST_WINIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_RD1: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      sel_q     <= DIV_NUM0;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      clr_cmd_q <= clr_cmd_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy held after result");

endmodule
